// ===== hdl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// isp_pkg - infix to postfix converter shared definitions
// Stack sizing, command codes, the command record and character classifiers.
// ----------------------------------------------------------------------------
package isp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CHAR_W      = 8;
  localparam int PREC_W      = 2;
  localparam int CMD_W       = 3;
  localparam int CMDQ_DEPTH  = 2;
  localparam int QPTR_W      = $clog2(CMDQ_DEPTH);
  localparam int QCNT_W      = $clog2(CMDQ_DEPTH + 1);

  // command codes from the front end
  localparam logic [CMD_W-1:0] CMD_OPERAND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_OPENER   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_OPERATOR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSER   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_END      = 3'd4;

  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [CMD_W-1:0]  code;
    logic [CHAR_W-1:0] ch;
    logic [PREC_W-1:0] prec;
  } cmd_t;

  function automatic logic [PREC_W-1:0] prec_of(input logic [CHAR_W-1:0] c);
    logic [PREC_W-1:0] p;
    p = 2'd0;
    if (c == CH_CARET) p = 2'd3;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    else if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    return p;
  endfunction

  function automatic logic is_opener(input logic [CHAR_W-1:0] c);
    return (c == CH_LPAREN) || (c == CH_LBRACE) || (c == CH_LBRACK);
  endfunction

  function automatic logic is_closer(input logic [CHAR_W-1:0] c);
    return (c == CH_RPAREN) || (c == CH_RBRACE) || (c == CH_RBRACK);
  endfunction

  function automatic logic is_operand(input logic [CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

// ===== hdl/isp_if.sv =====
// ----------------------------------------------------------------------------
// isp_if - converter channel interfaces
// Valid/ready channels for input characters and postfix results.
// ----------------------------------------------------------------------------
interface isp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_char;

  modport source (output valid, kind, in_char, input ready);
  modport sink   (input valid, kind, in_char, output ready);
endinterface

interface isp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       expr_done;
  logic       error_flag;

  modport source (output valid, out_char, run_last, expr_done, error_flag, input ready);
  modport sink   (input valid, out_char, run_last, expr_done, error_flag, output ready);
endinterface

// ===== hdl/isp_front.sv =====
// ----------------------------------------------------------------------------
// isp_front - input classifier
// Turns each input transaction into a command; unknown characters are dropped.
// ----------------------------------------------------------------------------
module isp_front import isp_pkg::*; (
  isp_in_if.sink     in_ch,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  logic keep;

  always_comb begin
    keep      = 1'b1;
    cmd.ch    = in_ch.in_char;
    cmd.prec  = prec_of(in_ch.in_char);
    cmd.code  = CMD_OPERAND;
    priority if (in_ch.kind) begin
      cmd.code = CMD_END;
    end else if (is_opener(in_ch.in_char)) begin
      cmd.code = CMD_OPENER;
    end else if (is_operand(in_ch.in_char)) begin
      cmd.code = CMD_OPERAND;
    end else if (cmd.prec != '0) begin
      cmd.code = CMD_OPERATOR;
    end else if (is_closer(in_ch.in_char)) begin
      cmd.code = CMD_CLOSER;
    end else begin
      keep = 1'b0;
    end
  end

  // ignored characters are still taken, just not queued
  assign cmd_valid   = in_ch.valid && keep;
  assign in_ch.ready = cmd_ready;

endmodule

// ===== hdl/isp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// isp_cmd_fifo - command queue
// Small register FIFO between the classifier and the stack engine.
// ----------------------------------------------------------------------------
module isp_cmd_fifo import isp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t              q_r [CMDQ_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign wr_ready = cnt_r != QCNT_W'(CMDQ_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = q_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (do_wr && !do_rd) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) q_r[wptr_r] <= wr_data;
  end

endmodule

// ===== hdl/isp_back.sv =====
// ----------------------------------------------------------------------------
// isp_back - operator stack engine
// One stack operation per cycle, emitting ones only when the output stage is free;
// top and next entry sit in registers, deeper ones in a RAM with registered read.
// ----------------------------------------------------------------------------
module isp_back import isp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  isp_out_if.source   out_ch
);

  logic [CHAR_W-1:0] stk_mem [STACK_DEPTH];

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CHAR_W-1:0] top_r, top_nxt;
  logic [CHAR_W-1:0] below_r;
  logic              err_r, err_nxt;

  logic              out_vld_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r, out_done_r, out_err_r;

  logic              out_free, have, one, full;
  logic              emit, e_last, e_done, done, pop, push;
  logic [CHAR_W-1:0] e_char;
  logic [PREC_W-1:0] top_prec, below_prec;
  logic              wr_en;
  logic [CNT_W-1:0]  wr_idx, rd_idx;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign out_free   = !out_vld_r || out_ch.ready;
  assign have       = cnt_r != '0;
  assign one        = cnt_r == CNT_W'(1);
  assign full       = cnt_r == CNT_W'(STACK_DEPTH);
  assign top_prec   = prec_of(top_r);
  assign below_prec = prec_of(below_r);

  always_comb begin
    emit    = 1'b0;
    e_char  = top_r;
    e_last  = 1'b0;
    e_done  = 1'b0;
    done    = 1'b0;
    pop     = 1'b0;
    push    = 1'b0;
    err_nxt = err_r;
    top_nxt = top_r;
    if (cmd_valid) begin
      unique case (cmd.code)
        CMD_OPERAND: begin
          if (out_free) begin
            emit   = 1'b1;
            e_char = cmd.ch;
            e_last = 1'b1;
            done   = 1'b1;
          end
        end
        CMD_OPENER: begin
          done = 1'b1;
          if (full) err_nxt = 1'b1;
          else push = 1'b1;
        end
        CMD_OPERATOR: begin
          if (have && top_prec >= cmd.prec) begin
            if (out_free) begin
              emit   = 1'b1;
              e_last = one || (below_prec < cmd.prec);
              if (e_last) begin
                // final pop and the push share a cycle: replace the top
                top_nxt = cmd.ch;
                done    = 1'b1;
              end else begin
                pop = 1'b1;
              end
            end
          end else begin
            done = 1'b1;
            if (full) err_nxt = 1'b1;
            else push = 1'b1;
          end
        end
        CMD_CLOSER: begin
          if (!have) begin
            err_nxt = 1'b1;
            done    = 1'b1;
          end else if (is_opener(top_r)) begin
            pop  = 1'b1;
            done = 1'b1;
          end else if (out_free) begin
            emit   = 1'b1;
            e_last = one || is_opener(below_r);
            pop    = 1'b1;
            if (one) begin
              err_nxt = 1'b1;
              done    = 1'b1;
            end
          end
        end
        CMD_END: begin
          if (out_free) begin
            emit = 1'b1;
            if (have) begin
              pop = 1'b1;
            end else begin
              e_char  = CH_NUL;
              e_last  = 1'b1;
              e_done  = 1'b1;
              err_nxt = 1'b0;
              done    = 1'b1;
            end
          end
        end
        default: done = 1'b1;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    wr_en   = 1'b0;
    if (push) begin
      wr_en   = have;
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign wr_idx  = cnt_r - CNT_W'(1);
  assign wr_addr = wr_idx[ADDR_W-1:0];
  assign rd_idx  = cnt_nxt - CNT_W'(2);
  assign rd_addr = rd_idx[ADDR_W-1:0];

  assign cmd_ready = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      err_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      err_r <= err_nxt;
      if (emit) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  // payload and stack storage
  always_ff @(posedge clk) begin
    if (push) top_r <= cmd.ch;
    else if (pop) top_r <= below_r;
    else top_r <= top_nxt;
    if (wr_en) stk_mem[wr_addr] <= top_r;
    if (wr_en && wr_addr == rd_addr) below_r <= top_r;
    else below_r <= stk_mem[rd_addr];
    if (emit) begin
      out_char_r <= e_char;
      out_last_r <= e_last;
      out_done_r <= e_done;
      out_err_r  <= err_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_char   = out_char_r;
  assign out_ch.run_last   = out_last_r;
  assign out_ch.expr_done  = out_done_r;
  assign out_ch.error_flag = out_err_r;

endmodule

// ===== hdl/infix_to_postfix_converter_unit.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit - shunting-yard infix to postfix converter
// Character stream in, postfix character stream out, with a sticky error.
// ----------------------------------------------------------------------------
// Path: an input is held in the command queue, its results in the engine's
//   output register. Per item: an operand is emitted as is; an operator
//   pops each entry of equal or higher precedence, the push riding on the
//   last pop; a closer pops operators, then its opener; end pops every entry
//   then emits the terminator. One stack operation per cycle when output is free.
// Reset: rst_n synchronous, active low; clears stack count, error, queue, output.
module infix_to_postfix_converter_unit import isp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  isp_in_if.sink     in_ch,
  isp_out_if.source  out_ch
);

  // front end -> queue
  logic cf_valid, cf_ready;
  cmd_t cf_cmd;

  // queue -> stack engine
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // Classifier: one input transaction per cycle while the queue has room.
  // Unknown characters are consumed here and never reach the engine.
  isp_front u_front (
    .in_ch     (in_ch),
    .cmd_valid (cf_valid),
    .cmd       (cf_cmd),
    .cmd_ready (cf_ready)
  );

  // Two-entry queue decouples input stalls from stack work.
  isp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cf_valid),
    .wr_ready (cf_ready),
    .wr_data  (cf_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_cmd)
  );

  // Stack engine: pops/pushes one entry per cycle; results go through a registered
  // output stage, but while the sink stalls only work that emits nothing goes on.
  isp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/isp_checker.sv =====
// ----------------------------------------------------------------------------
// isp_checker - converter port assertions
// Checks result stream properties seen on the top level ports.
// ----------------------------------------------------------------------------
module isp_checker import isp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              run_last,
  input logic              expr_done,
  input logic              error_flag
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(run_last) && $stable(expr_done) && $stable(error_flag))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && expr_done |-> run_last && out_char == CH_NUL)
    else $error("bad terminating result");

  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !expr_done |-> out_char != CH_NUL)
    else $error("null character emitted");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && error_flag && !run_last |=> !out_valid || error_flag)
    else $error("error flag dropped inside a run");

endmodule

bind infix_to_postfix_converter_unit isp_checker u_isp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.out_char),
  .run_last   (out_ch.run_last),
  .expr_done  (out_ch.expr_done),
  .error_flag (out_ch.error_flag)
);

// ===== bench/tb_infix_to_postfix_converter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter_unit - shunting-yard converter bench
// Drives infix characters and end markers over valid/ready and keeps its own
// operator stack to predict every postfix character. A tracker checks each
// result in order. Both channels idle at random, and the stack is pushed past
// its depth. The input is also made to stall behind a blocked output.
// ----------------------------------------------------------------------------

typedef struct {
  logic [7:0] ch;
  logic       last;
  logic       done;
  logic       err;
} postfix_emit_t;

// Predicts the postfix stream and matches the block's results against it.
class postfix_tracker;
  logic [7:0]    op_stack [isp_pkg::STACK_DEPTH];
  int            stack_used;
  bit            err_seen;
  postfix_emit_t postfix_due[$];
  int            mismatches;
  int            results_seen;
  int            overflows;
  int            orphan_closers;
  int            expressions;
  int            longest_run;

  function new();
    stack_used = 0;
    err_seen   = 0;
  endfunction

  function int rank(logic [7:0] c);
    if (c == isp_pkg::CH_CARET) return 3;
    if (c == isp_pkg::CH_STAR || c == isp_pkg::CH_SLASH) return 2;
    if (c == isp_pkg::CH_PLUS || c == isp_pkg::CH_MINUS) return 1;
    return 0;
  endfunction

  function bit opens(logic [7:0] c);
    return c == isp_pkg::CH_LPAREN || c == isp_pkg::CH_LBRACE || c == isp_pkg::CH_LBRACK;
  endfunction

  function bit closes(logic [7:0] c);
    return c == isp_pkg::CH_RPAREN || c == isp_pkg::CH_RBRACE || c == isp_pkg::CH_RBRACK;
  endfunction

  function bit plain(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9");
  endfunction

  function void push_op(logic [7:0] c);
    if (stack_used >= isp_pkg::STACK_DEPTH) begin
      err_seen = 1;
      overflows++;
    end else begin
      op_stack[stack_used] = c;
      stack_used++;
    end
  endfunction

  // One accepted input transaction: append the results it causes.
  function void convert_char(bit kind, logic [7:0] c);
    postfix_emit_t run[$];
    postfix_emit_t e;
    bit            found;
    int            p;
    e.last = 0;
    if (kind) begin
      while (stack_used > 0) begin
        stack_used--;
        e.ch = op_stack[stack_used]; e.done = 0; e.err = err_seen;
        run.push_back(e);
      end
      e.ch = isp_pkg::CH_NUL; e.done = 1; e.err = err_seen;
      run.push_back(e);
      err_seen = 0;
      expressions++;
    end else if (opens(c)) begin
      push_op(c);
    end else if (plain(c)) begin
      e.ch = c; e.done = 0; e.err = err_seen;
      run.push_back(e);
    end else if (rank(c) > 0) begin
      p = rank(c);
      while (stack_used > 0 && rank(op_stack[stack_used-1]) >= p) begin
        stack_used--;
        e.ch = op_stack[stack_used]; e.done = 0; e.err = err_seen;
        run.push_back(e);
      end
      push_op(c);
    end else if (closes(c)) begin
      found = 0;
      while (stack_used > 0 && !found) begin
        stack_used--;
        if (opens(op_stack[stack_used])) begin
          found = 1;
        end else begin
          e.ch = op_stack[stack_used]; e.done = 0; e.err = err_seen;
          run.push_back(e);
        end
      end
      if (!found) begin
        err_seen = 1;
        orphan_closers++;
      end
    end
    if (run.size() > 0) begin
      e = run.pop_back();
      e.last = 1;
      run.push_back(e);
      if (run.size() > longest_run) longest_run = run.size();
    end
    foreach (run[i]) postfix_due.push_back(run[i]);
  endfunction

  function void report(string what);
    if (mismatches < 10) $display("%t postfix mismatch: %s", $time, what);
    mismatches++;
  endfunction

  // One accepted result transaction, checked against the oldest expectation.
  function void match_emit(logic [7:0] ch, logic last, logic done, logic err);
    postfix_emit_t e;
    results_seen++;
    if (postfix_due.size() == 0) begin
      report($sformatf("unexpected result char=%h last=%b done=%b err=%b",
                       ch, last, done, err));
      return;
    end
    e = postfix_due.pop_front();
    if (ch !== e.ch || last !== e.last || done !== e.done || err !== e.err)
      report($sformatf("exp char=%h last=%b done=%b err=%b, got char=%h last=%b done=%b err=%b",
                       e.ch, e.last, e.done, e.err, ch, last, done, err));
  endfunction
endclass

module tb_infix_to_postfix_converter_unit;
  import isp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side
  localparam int LONG_HOLD      = 150;   // output hold-off that backs the block up
  localparam int RANDOM_ITEMS   = 280;
  localparam int CALM_AFTER     = 240;   // random items after which idling stops
  localparam int TAIL_CYCLES    = 40;

  logic clk;
  logic rst_n;

  isp_in_if  in_if ();
  isp_out_if out_if ();

  infix_to_postfix_converter_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  postfix_tracker tracker;

  bit calm;         // no idling on either side once set
  bit hold_req;     // asks the receiver for one long hold-off
  int items_sent;
  int noise_sent;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready low in random bursts, or one long hold when asked.
  // Only one assignment to ready per falling edge.
  // --------------------------------------------------------------------------
  initial begin
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        hold_req = 0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and watchdog, both on the rising edge.
  // The watchdog only counts cycles in which neither side moves a transaction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        tracker.match_emit(out_if.out_char, out_if.run_last, out_if.expr_done,
                           out_if.error_flag);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles, %0d results still due",
                   quiet_cycles, tracker.postfix_due.size());
          $display("tb_infix_to_postfix_converter_unit: done, errors");
          $finish;
        end
      end
    end
  end

  // Random pause on the sending side with valid low, only before calm is set.
  task automatic sender_gap();
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offer one input transaction and hand it to the predictor when taken.
  task automatic send_item(input bit kind, input logic [7:0] ch);
    sender_gap();
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.in_char <= ch;
    do @(posedge clk); while (!in_if.ready);
    tracker.convert_char(kind, ch);
    items_sent++;
  endtask

  // Sender waits until every predicted result has come out.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tracker.postfix_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h41, 8'h5A));
      1:       return 8'($urandom_range(8'h61, 8'h7A));
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  function automatic logic [7:0] pick_opener();
    case ($urandom_range(0, 2))
      0:       return CH_LPAREN;
      1:       return CH_LBRACE;
      default: return CH_LBRACK;
    endcase
  endfunction

  function automatic logic [7:0] pick_closer();
    case ($urandom_range(0, 2))
      0:       return CH_RPAREN;
      1:       return CH_RBRACE;
      default: return CH_RBRACK;
    endcase
  endfunction

  // One random expression. Sloppy ones carry stray bytes and unbalanced
  // brackets; the rest are well formed with random content.
  task automatic send_expr(input bit sloppy);
    int terms;
    int open_cnt;
    terms    = $urandom_range(1, 8);
    open_cnt = 0;
    for (int i = 0; i < terms; i++) begin
      if ($urandom_range(0, 3) == 0 && open_cnt < 8) begin
        send_item(1'b0, pick_opener());
        open_cnt++;
      end
      if (sloppy && $urandom_range(0, 4) == 0) begin
        send_item(1'b0, 8'($urandom_range(0, 255)));
        noise_sent++;
      end
      send_item(1'b0, pick_operand());
      if (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        send_item(1'b0, pick_closer());
        open_cnt--;
      end
      if (i < terms - 1) send_item(1'b0, pick_operator());
    end
    if (sloppy) begin
      // either a closer with nothing to match, or openers left for the flush
      if ($urandom_range(0, 1) == 0)
        repeat (open_cnt + 1) send_item(1'b0, pick_closer());
    end else begin
      repeat (open_cnt) send_item(1'b0, pick_closer());
    end
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // Deep nesting: mostly openers, so the stack fills and may overflow.
  // The end item then flushes up to a full stack plus the terminator.
  task automatic send_deep(input int pushes);
    for (int i = 0; i < pushes; i++) begin
      if ($urandom_range(0, 5) == 0) send_item(1'b0, pick_operator());
      else send_item(1'b0, pick_opener());
    end
    send_item(1'b0, pick_operand());
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int errors;
    tracker       = new();
    calm          = 0;
    hold_req      = 0;
    items_sent    = 0;
    noise_sent    = 0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.kind    = 1'b0;
    in_if.in_char = 8'h00;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: operand range ends, every operator and bracket kind,
    // precedence order, a closer matching a different opener kind, a closer
    // with no opener, ignored bytes at both ends of the range, openers left
    // for the flush, and end items with either in_char extreme.
    send_item(1'b0, "A");
    send_item(1'b0, CH_PLUS);
    send_item(1'b0, "b");
    send_item(1'b0, CH_STAR);
    send_item(1'b0, CH_LPAREN);
    send_item(1'b0, "Z");
    send_item(1'b0, CH_MINUS);
    send_item(1'b0, "9");
    send_item(1'b0, CH_RPAREN);
    send_item(1'b0, CH_CARET);
    send_item(1'b0, "0");
    send_item(1'b0, CH_SLASH);
    send_item(1'b0, "z");
    send_item(1'b1, 8'h00);
    send_item(1'b0, CH_LBRACE);
    send_item(1'b0, "a");
    send_item(1'b0, CH_RBRACK);
    send_item(1'b0, CH_RBRACE);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CH_LBRACK);
    send_item(1'b0, "5");
    send_item(1'b1, 8'hFF);
    drain();

    // Random part. The first deep run nearly always overflows and runs into
    // the long output hold-off, so the block fills and stalls its input.
    items_sent = 0;
    noise_sent = 0;
    hold_req   = 1;
    send_deep(STACK_DEPTH + 2);
    while (items_sent - noise_sent < RANDOM_ITEMS) begin
      if (items_sent - noise_sent >= CALM_AFTER) calm = 1;
      if (items_sent - noise_sent >= RANDOM_ITEMS / 2 && tracker.overflows < 2) begin
        drain();
        send_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4));
      end else begin
        send_expr($urandom_range(0, 3) == 0);
      end
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d expressions, %0d input and %0d result transactions",
             tracker.expressions, items_sent, tracker.results_seen);
    $display("stack overflows %0d, unmatched closers %0d, longest result run %0d",
             tracker.overflows, tracker.orphan_closers, tracker.longest_run);
    errors = tracker.mismatches + tracker.postfix_due.size();
    if (errors == 0) begin
      $display("tb_infix_to_postfix_converter_unit: done, clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", tracker.mismatches,
               tracker.postfix_due.size());
      $display("tb_infix_to_postfix_converter_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/isp_pkg.sv
hdl/isp_if.sv
hdl/isp_front.sv
hdl/isp_cmd_fifo.sv
hdl/isp_back.sv
hdl/infix_to_postfix_converter_unit.sv
hdl/isp_checker.sv
bench/tb_infix_to_postfix_converter_unit.sv
